[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cond implies nxt in the next cycle, outside reset.
`define JSV_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);

// Checks that cond always holds, outside reset.
`define JSV_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

[rtl/jsv_pkg.sv]
`default_nettype none
package jsv_pkg;

  localparam int MaxDepth = 64;
  localparam int StackSize = MaxDepth + 1;
  localparam int CountW = $clog2(StackSize + 1);
  localparam int StackIdxW = $clog2(StackSize);

  localparam logic [1:0] VerdictRun = 2'd0;
  localparam logic [1:0] VerdictValid = 2'd1;
  localparam logic [1:0] VerdictInvalid = 2'd2;

  typedef struct packed {
    logic [7:0] doc_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [6:0] open_depth;
    logic       document_end;
  } out_req_t;

  // Byte class worked out by the front end.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       is_ws;
    logic       is_digit;
    logic       is_hex;
    logic       is_expo;
  } cls_req_t;

  typedef enum logic [4:0] {
    ST_VALUE, ST_ARR_FIRST, ST_OBJ_FIRST, ST_KEY, ST_COLON, ST_AFTER,
    ST_STR, ST_ESC, ST_HEX, ST_KSTR, ST_KESC, ST_KHEX,
    ST_LTRUE, ST_LFALSE, ST_LNULL,
    ST_NMINUS, ST_NZERO, ST_NINT, ST_NDOT, ST_NFRAC, ST_NE, ST_NESIGN, ST_NEXP
  } gram_state_t;

  function automatic logic [7:0] lit_char(input gram_state_t st, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    unique case (st)
      ST_LTRUE: begin
        unique case (pos)
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      ST_LFALSE: begin
        unique case (pos)
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      ST_LNULL: begin
        unique case (pos)
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/jsv_front.sv]
`default_nettype none
// Accepts bytes and classifies them into a two-entry queue.
module jsv_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire jsv_pkg::in_req_t  in_req,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output jsv_pkg::cls_req_t      q_req
);
  jsv_pkg::cls_req_t mem_r [2];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;
  jsv_pkg::cls_req_t cls;
  logic [7:0] c;

  always_comb begin
    c = in_req.doc_byte;
    cls.ch = c;
    cls.last = in_req.last_byte;
    cls.is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    cls.is_digit = (c >= "0") && (c <= "9");
    cls.is_hex = cls.is_digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    cls.is_expo = (c == "e") || (c == "E");
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = mem_r[rd_r];

  always_comb begin
    rd_nxt = rd_r ^ q_pop;
    wr_nxt = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= cls;
    end
  end
endmodule
`default_nettype wire

[rtl/jsv_back.sv]
`default_nettype none
// Grammar state machine, kind stack and output register.
module jsv_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire jsv_pkg::cls_req_t  q_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output jsv_pkg::out_req_t       out_req
);
  localparam int CW = jsv_pkg::CountW;
  localparam int SW = jsv_pkg::StackIdxW;

  jsv_pkg::gram_state_t st_r, st_nxt;
  // Kind stack: the two top entries sit in registers, the rest in a memory
  // that is read with a registered output when the stack shrinks.
  logic stk_mem [jsv_pkg::StackSize];
  logic top_r, top_nxt, below_r;
  logic stk_push, stk_pop, kind_in;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0] lpos_r, lpos_nxt, hex_r, hex_nxt;
  logic err_r, err_nxt, term_r, term_nxt;
  logic ov_r;
  jsv_pkg::out_req_t or_r, or_nxt;
  logic [7:0] c;
  logic top;
  logic done;

  assign q_pop = q_valid && (!ov_r || !out_stall);
  assign out_valid = ov_r;
  assign out_req = or_r;
  assign c = q_req.ch;
  assign top = (cnt_r != '0) ? top_r : 1'b0;

  always_comb begin
    logic go;
    logic [2:0] llen;
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    lpos_nxt = lpos_r;
    hex_nxt = hex_r;
    err_nxt = err_r;
    term_nxt = term_r;
    stk_push = 1'b0;
    stk_pop = 1'b0;
    kind_in = 1'b0;
    go = 1'b0;
    llen = 3'd4;
    if (!term_r && !err_r && c != 8'h00) begin
      unique case (st_r)
        jsv_pkg::ST_VALUE: go = !q_req.is_ws;
        jsv_pkg::ST_ARR_FIRST: begin
          if (c == "]") begin
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
              stk_pop = 1'b1;
            end
            st_nxt = jsv_pkg::ST_AFTER;
          end else go = !q_req.is_ws;
        end
        jsv_pkg::ST_OBJ_FIRST, jsv_pkg::ST_KEY: begin
          if (!q_req.is_ws) begin
            if (c == "}" && st_r == jsv_pkg::ST_OBJ_FIRST) begin
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - 1'b1;
                stk_pop = 1'b1;
              end
              st_nxt = jsv_pkg::ST_AFTER;
            end else if (c == "\"") st_nxt = jsv_pkg::ST_KSTR;
            else err_nxt = 1'b1;
          end
        end
        jsv_pkg::ST_COLON: begin
          if (!q_req.is_ws) begin
            if (c == ":") st_nxt = jsv_pkg::ST_VALUE;
            else err_nxt = 1'b1;
          end
        end
        jsv_pkg::ST_STR, jsv_pkg::ST_KSTR: begin
          if (c < 8'h20) err_nxt = 1'b1;
          else if (c == "\"")
            st_nxt = (st_r == jsv_pkg::ST_STR) ? jsv_pkg::ST_AFTER : jsv_pkg::ST_COLON;
          else if (c == "\\")
            st_nxt = (st_r == jsv_pkg::ST_STR) ? jsv_pkg::ST_ESC : jsv_pkg::ST_KESC;
        end
        jsv_pkg::ST_ESC, jsv_pkg::ST_KESC: begin
          if (c == "u") begin
            hex_nxt = 3'd4;
            st_nxt = (st_r == jsv_pkg::ST_ESC) ? jsv_pkg::ST_HEX : jsv_pkg::ST_KHEX;
          end else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                       c == "n" || c == "r" || c == "t")
            st_nxt = (st_r == jsv_pkg::ST_ESC) ? jsv_pkg::ST_STR : jsv_pkg::ST_KSTR;
          else err_nxt = 1'b1;
        end
        jsv_pkg::ST_HEX, jsv_pkg::ST_KHEX: begin
          if (!q_req.is_hex) err_nxt = 1'b1;
          else begin
            hex_nxt = (hex_r != 3'd0) ? hex_r - 3'd1 : 3'd0;
            if (hex_nxt == 3'd0)
              st_nxt = (st_r == jsv_pkg::ST_HEX) ? jsv_pkg::ST_STR : jsv_pkg::ST_KSTR;
          end
        end
        jsv_pkg::ST_LTRUE, jsv_pkg::ST_LFALSE, jsv_pkg::ST_LNULL: begin
          llen = (st_r == jsv_pkg::ST_LFALSE) ? 3'd5 : 3'd4;
          if (lpos_r >= llen || c != jsv_pkg::lit_char(st_r, lpos_r)) err_nxt = 1'b1;
          else if (lpos_r + 3'd1 == llen) begin
            lpos_nxt = 3'd0;
            st_nxt = jsv_pkg::ST_AFTER;
          end else lpos_nxt = lpos_r + 3'd1;
        end
        jsv_pkg::ST_NMINUS: begin
          if (c == "0") st_nxt = jsv_pkg::ST_NZERO;
          else if (q_req.is_digit) st_nxt = jsv_pkg::ST_NINT;
          else err_nxt = 1'b1;
        end
        jsv_pkg::ST_NDOT: begin
          if (q_req.is_digit) st_nxt = jsv_pkg::ST_NFRAC; else err_nxt = 1'b1;
        end
        jsv_pkg::ST_NE: begin
          if (c == "+" || c == "-") st_nxt = jsv_pkg::ST_NESIGN;
          else if (q_req.is_digit) st_nxt = jsv_pkg::ST_NEXP;
          else err_nxt = 1'b1;
        end
        jsv_pkg::ST_NESIGN: begin
          if (q_req.is_digit) st_nxt = jsv_pkg::ST_NEXP; else err_nxt = 1'b1;
        end
        default: begin
          // After-value and the number states that may end here.
          if (st_r == jsv_pkg::ST_AFTER ||
              (st_r == jsv_pkg::ST_NEXP && !q_req.is_digit) ||
              (st_r == jsv_pkg::ST_NFRAC && !q_req.is_digit && !q_req.is_expo) ||
              (st_r == jsv_pkg::ST_NINT && !q_req.is_digit && !q_req.is_expo &&
               c != ".") ||
              (st_r == jsv_pkg::ST_NZERO && !q_req.is_expo && c != ".")) begin
            st_nxt = jsv_pkg::ST_AFTER;
            if (!q_req.is_ws) begin
              if (cnt_r == '0) err_nxt = 1'b1;
              else if (c == ",") st_nxt = top ? jsv_pkg::ST_KEY : jsv_pkg::ST_VALUE;
              else if (c == (top ? "}" : "]")) begin
                cnt_nxt = cnt_r - 1'b1;
                stk_pop = 1'b1;
              end
              else err_nxt = 1'b1;
            end
          end else if (c == ".") st_nxt = jsv_pkg::ST_NDOT;
          else if (q_req.is_expo && st_r != jsv_pkg::ST_NEXP) st_nxt = jsv_pkg::ST_NE;
        end
      endcase
      if (go) begin
        if (cnt_r > CW'(jsv_pkg::MaxDepth)) err_nxt = 1'b1;
        else begin
          lpos_nxt = 3'd1;
          if (c == "\"") st_nxt = jsv_pkg::ST_STR;
          else if (c == "{" || c == "[") begin
            stk_push = 1'b1;
            kind_in = (c == "{");
            cnt_nxt = cnt_r + 1'b1;
            st_nxt = (c == "{") ? jsv_pkg::ST_OBJ_FIRST : jsv_pkg::ST_ARR_FIRST;
          end else if (c == "t") st_nxt = jsv_pkg::ST_LTRUE;
          else if (c == "f") st_nxt = jsv_pkg::ST_LFALSE;
          else if (c == "n") st_nxt = jsv_pkg::ST_LNULL;
          else if (c == "-") st_nxt = jsv_pkg::ST_NMINUS;
          else if (c == "0") st_nxt = jsv_pkg::ST_NZERO;
          else if (q_req.is_digit) st_nxt = jsv_pkg::ST_NINT;
          else err_nxt = 1'b1;
        end
      end
    end
    // Completeness test, on the state before a zero byte or after the last one.
    if (!term_r && !err_r && c == 8'h00) begin
      done = (st_r == jsv_pkg::ST_AFTER || st_r == jsv_pkg::ST_NZERO ||
              st_r == jsv_pkg::ST_NINT || st_r == jsv_pkg::ST_NFRAC ||
              st_r == jsv_pkg::ST_NEXP) && (cnt_r == '0);
      if (!done) err_nxt = 1'b1;
    end else begin
      done = (st_nxt == jsv_pkg::ST_AFTER || st_nxt == jsv_pkg::ST_NZERO ||
              st_nxt == jsv_pkg::ST_NINT || st_nxt == jsv_pkg::ST_NFRAC ||
              st_nxt == jsv_pkg::ST_NEXP) && (cnt_nxt == '0);
      if (q_req.last && !err_nxt && !term_r && !done) err_nxt = 1'b1;
    end
    if (c == 8'h00) term_nxt = 1'b1;
    // The new top of stack: a pushed kind, or the entry below on a pop.
    top_nxt = stk_push ? kind_in : (stk_pop ? below_r : top_r);
    or_nxt.verdict = err_nxt ? jsv_pkg::VerdictInvalid :
                     (q_req.last ? jsv_pkg::VerdictValid : jsv_pkg::VerdictRun);
    or_nxt.open_depth = cnt_nxt[6:0];
    or_nxt.document_end = q_req.last;
    if (q_req.last) begin
      st_nxt = jsv_pkg::ST_VALUE;
      cnt_nxt = '0;
      lpos_nxt = 3'd0;
      hex_nxt = 3'd0;
      err_nxt = 1'b0;
      term_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= jsv_pkg::ST_VALUE;
      cnt_r <= '0;
      lpos_r <= 3'd0;
      hex_r <= 3'd0;
      err_r <= 1'b0;
      term_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (q_pop) begin
        st_r <= st_nxt;
        cnt_r <= cnt_nxt;
        lpos_r <= lpos_nxt;
        hex_r <= hex_nxt;
        err_r <= err_nxt;
        term_r <= term_nxt;
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      or_r <= or_nxt;
      top_r <= top_nxt;
    end
  end

  // Entries at and below the top are only read after they were pushed, so the
  // memory needs no clearing. A pop fetches the entry two below the old top.
  always_ff @(posedge clk) begin
    if (q_pop && stk_push) begin
      stk_mem[SW'(cnt_r)] <= kind_in;
      below_r <= top_r;
    end else if (q_pop && stk_pop && cnt_r > CW'(2)) begin
      below_r <= stk_mem[SW'(cnt_r - CW'(3))];
    end
  end
endmodule
`default_nettype wire

[rtl/json_syntax_validator_top.sv]
`default_nettype none
// JSON syntax validator: one document byte per request in, one verdict request
// out for every byte, at a sustained rate of one byte per clock cycle while the
// output is not stalled. The front end classifies each byte into a two-entry
// queue; the back end runs the grammar state machine and the container stack
// on each byte that it pops from the queue and holds its result in an output
// register. An accepted byte is first written into the queue; once it is popped,
// its result is held in the output register. Verdict 0 means no error so far, 1
// a valid document at its last byte, 2 an invalid document (an error is sticky).
// A zero byte ends the text, and following bytes up to the last one are
// ignored. The grammar state, depth count and error flags clear after the last
// byte of a document.
`include "assert_macros.svh"
module json_syntax_validator_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire jsv_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output jsv_pkg::out_req_t      out_req
);
  logic q_valid;
  logic q_pop;
  jsv_pkg::cls_req_t q_req;

  // Front end: byte classification and queue.
  jsv_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
  );

  // Back end: grammar, stack and result register.
  jsv_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
  );

  // A result that closes a document carries a final verdict.
  `JSV_ASSERT_ALWAYS(a_end_verdict, clk, rst_n,
    !out_valid || !out_req.document_end || out_req.verdict != jsv_pkg::VerdictRun,
    "final result without final verdict")
  // A popped queue entry always yields a valid result next cycle.
  `JSV_ASSERT_NEXT(a_pop_out, clk, rst_n, q_pop, out_valid, "pop lost a result")
  // Verdict code 3 never occurs.
  `JSV_ASSERT_ALWAYS(a_verdict_code, clk, rst_n,
    !out_valid || out_req.verdict != 2'd3, "bad verdict code")
endmodule
`default_nettype wire
